/* design/ttb_pkg.sv */
// ----------------------------------------------------------------------------
// ttb_pkg: shared definitions for the triangle tangent/bitangent block
// Widths, sequencing constants and the command/status words that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ttb_pkg;

   localparam int POS_W      = 24;
   localparam int UV_W       = 16;
   localparam int OUT_FRAC   = 14;
   localparam int OUT_W      = OUT_FRAC + 2;

   localparam int EDGE_W     = POS_W + 1;
   localparam int DUV_W      = UV_W + 1;
   localparam int RAW_W      = POS_W + UV_W + 3;

   // normalized magnitudes sit in [2^29, 2^30)
   localparam int NORM_BITS  = 30;
   localparam int MAG_W      = (RAW_W > NORM_BITS + 1) ? RAW_W : NORM_BITS + 1;

   localparam int MUL_A_W    = (EDGE_W > NORM_BITS + 1) ? EDGE_W : NORM_BITS + 1;
   localparam int MUL_B_W    = (DUV_W > NORM_BITS + 1) ? DUV_W : NORM_BITS + 1;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;

   localparam int SUM_W      = 2 * NORM_BITS + 2;
   localparam int LEN_W      = NORM_BITS + 1;
   localparam int SQRT_STEPS = LEN_W;
   localparam int DIV_W      = LEN_W + OUT_FRAC + 1;
   localparam int Q_W        = OUT_FRAC + 1;

   localparam int MUL_STEPS  = 14;
   localparam int SQ_STEPS   = 3;
   localparam int CNT_W      = $clog2(SQRT_STEPS + 1);

   typedef logic signed [POS_W-1:0]   pos_type;
   typedef logic signed [UV_W-1:0]    uv_type;
   typedef logic signed [EDGE_W-1:0]  edge_type;
   typedef logic signed [DUV_W-1:0]   duv_type;
   typedef logic signed [RAW_W-1:0]   raw_type;
   typedef logic        [MAG_W-1:0]   mag_type;
   typedef logic signed [MUL_A_W-1:0] mula_type;
   typedef logic signed [MUL_B_W-1:0] mulb_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic        [SUM_W-1:0]   sum_type;
   typedef logic        [LEN_W-1:0]   len_type;
   typedef logic        [DIV_W-1:0]   div_type;
   typedef logic        [Q_W-1:0]     quo_type;
   typedef logic signed [OUT_W-1:0]   out_type;
   typedef logic        [CNT_W-1:0]   cnt_type;

   typedef struct packed {
      logic    hold_wr;
      logic    hold_sel;
      logic    load_third;
      logic    mul_step;
      logic    load_degen;
      logic    zero_all;
      logic    norm_load;
      logic    norm_vec;
      logic    norm_shift;
      logic    zero_vec;
      logic    sq_step;
      logic    sqrt_step;
      logic    div_init;
      logic    div_step;
      logic    div_store;
      cnt_type idx;
      logic    vec;
      logic [1:0] comp;
   } cmd_type;

   typedef struct packed {
      logic det_zero;
      logic m_zero;
      logic norm_ok;
   } status_type;

endpackage

/* design/ttb_datapath.sv */
// ----------------------------------------------------------------------------
// ttb_datapath: corner storage, shared multiplier, normalizer, root and divider
// Executes one controller command per cycle.
// ----------------------------------------------------------------------------
module ttb_datapath (
   input  logic                 clock,
   input  ttb_pkg::cmd_type     cmd,
   input  ttb_pkg::pos_type     vertex_x,
   input  ttb_pkg::pos_type     vertex_y,
   input  ttb_pkg::pos_type     vertex_z,
   input  ttb_pkg::uv_type      tex_u,
   input  ttb_pkg::uv_type      tex_v,
   output ttb_pkg::status_type  status,
   output ttb_pkg::out_type     tangent_x,
   output ttb_pkg::out_type     tangent_y,
   output ttb_pkg::out_type     tangent_z,
   output ttb_pkg::out_type     bitangent_x,
   output ttb_pkg::out_type     bitangent_y,
   output ttb_pkg::out_type     bitangent_z,
   output logic                 degenerate
);

   ttb_pkg::pos_type  hold_pos_ff [2][3];
   ttb_pkg::uv_type   hold_uv_ff  [2][2];
   ttb_pkg::edge_type e0_ff [3];
   ttb_pkg::edge_type e1_ff [3];
   ttb_pkg::duv_type  du0_ff, dv0_ff, du1_ff, dv1_ff;
   ttb_pkg::prod_type prod_ff;
   ttb_pkg::raw_type  acc_ff;
   ttb_pkg::raw_type  raw_ff [7];
   ttb_pkg::mag_type  mag_ff [3];
   logic              neg_ff [3];
   ttb_pkg::sum_type  sum_ff, root_ff, sq_bit_ff;
   ttb_pkg::div_type  rem_ff;
   ttb_pkg::quo_type  quo_ff;
   ttb_pkg::out_type  tan_ff  [3];
   ttb_pkg::out_type  btan_ff [3];
   logic              degen_ff;

   ttb_pkg::pos_type  cur_pos [3];
   ttb_pkg::mula_type mul_a;
   ttb_pkg::mulb_type mul_b;
   logic [2:0]        pair;
   logic [2:0]        acc_pair;
   logic [1:0]        c_rt, c_rb;
   ttb_pkg::cnt_type  acc_idx;
   ttb_pkg::mag_type  m_c;
   ttb_pkg::sum_type  trial;
   ttb_pkg::len_type  len;
   ttb_pkg::div_type  div_sub;
   ttb_pkg::quo_type  quo_fin;
   ttb_pkg::out_type  store_val;
   logic              det_neg;

   assign cur_pos[0] = vertex_x;
   assign cur_pos[1] = vertex_y;
   assign cur_pos[2] = vertex_z;

   assign det_neg = raw_ff[0][ttb_pkg::RAW_W-1];
   assign len     = root_ff[ttb_pkg::LEN_W-1:0];
   assign trial   = root_ff + sq_bit_ff;
   assign div_sub = ttb_pkg::div_type'(len) << cmd.idx;
   assign quo_fin = quo_ff;
   assign store_val = neg_ff[cmd.comp] ? -ttb_pkg::out_type'(quo_fin)
                                       :  ttb_pkg::out_type'(quo_fin);

   always_comb begin
      m_c = mag_ff[0];
      if (mag_ff[1] > m_c) m_c = mag_ff[1];
      if (mag_ff[2] > m_c) m_c = mag_ff[2];
   end

   assign status.det_zero = (raw_ff[0] == '0);
   assign status.m_zero   = (m_c == '0);
   assign status.norm_ok  = ((m_c >> ttb_pkg::NORM_BITS) == '0) &&
                            m_c[ttb_pkg::NORM_BITS-1];

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      pair  = cmd.idx[3:1];
      c_rt  = 2'(pair - 3'd1);
      c_rb  = 2'(pair - 3'd4);
      if (cmd.mul_step) begin
         case (pair)
            3'd0: begin
               mul_a = ttb_pkg::mula_type'(cmd.idx[0] ? dv0_ff : du0_ff);
               mul_b = ttb_pkg::mulb_type'(cmd.idx[0] ? du1_ff : dv1_ff);
            end
            3'd1, 3'd2, 3'd3: begin
               mul_a = ttb_pkg::mula_type'(cmd.idx[0] ? e1_ff[c_rt] : e0_ff[c_rt]);
               mul_b = ttb_pkg::mulb_type'(cmd.idx[0] ? dv0_ff : dv1_ff);
            end
            3'd4, 3'd5, 3'd6: begin
               mul_a = ttb_pkg::mula_type'(cmd.idx[0] ? e0_ff[c_rb] : e1_ff[c_rb]);
               mul_b = ttb_pkg::mulb_type'(cmd.idx[0] ? du1_ff : du0_ff);
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end else if (cmd.sq_step && cmd.idx < ttb_pkg::cnt_type'(ttb_pkg::SQ_STEPS)) begin
         mul_a = ttb_pkg::mula_type'(signed'({1'b0,
                    mag_ff[cmd.idx[1:0]][ttb_pkg::NORM_BITS-1:0]}));
         mul_b = ttb_pkg::mulb_type'(signed'({1'b0,
                    mag_ff[cmd.idx[1:0]][ttb_pkg::NORM_BITS-1:0]}));
      end
   end

   assign acc_idx  = cmd.idx - ttb_pkg::cnt_type'(1);
   assign acc_pair = acc_idx[3:1];

   always_ff @(posedge clock) begin
      // corner capture
      if (cmd.hold_wr) begin
         for (int i = 0; i < 3; i++) hold_pos_ff[cmd.hold_sel][i] <= cur_pos[i];
         hold_uv_ff[cmd.hold_sel][0] <= tex_u;
         hold_uv_ff[cmd.hold_sel][1] <= tex_v;
      end
      if (cmd.load_third) begin
         for (int i = 0; i < 3; i++) begin
            e0_ff[i] <= ttb_pkg::edge_type'(hold_pos_ff[1][i]) -
                        ttb_pkg::edge_type'(hold_pos_ff[0][i]);
            e1_ff[i] <= ttb_pkg::edge_type'(cur_pos[i]) -
                        ttb_pkg::edge_type'(hold_pos_ff[0][i]);
         end
         du0_ff <= ttb_pkg::duv_type'(hold_uv_ff[1][0]) - ttb_pkg::duv_type'(hold_uv_ff[0][0]);
         dv0_ff <= ttb_pkg::duv_type'(hold_uv_ff[1][1]) - ttb_pkg::duv_type'(hold_uv_ff[0][1]);
         du1_ff <= ttb_pkg::duv_type'(tex_u) - ttb_pkg::duv_type'(hold_uv_ff[0][0]);
         dv1_ff <= ttb_pkg::duv_type'(tex_v) - ttb_pkg::duv_type'(hold_uv_ff[0][1]);
      end

      // multiply, then accumulate the previous product in the next cycle
      if (cmd.mul_step || cmd.sq_step)
         prod_ff <= ttb_pkg::prod_type'(mul_a) * ttb_pkg::prod_type'(mul_b);
      if (cmd.mul_step && cmd.idx != '0) begin
         if (!acc_idx[0])
            acc_ff <= ttb_pkg::raw_type'(prod_ff);
         else
            raw_ff[acc_pair] <= acc_ff - ttb_pkg::raw_type'(prod_ff);
      end

      // magnitudes and signs of one raw vector; sign flips when det < 0
      if (cmd.norm_load) begin
         for (int i = 0; i < 3; i++) begin
            if (cmd.norm_vec) begin
               neg_ff[i] <= det_neg ? (!raw_ff[4+i][ttb_pkg::RAW_W-1] && raw_ff[4+i] != '0)
                                    : raw_ff[4+i][ttb_pkg::RAW_W-1];
               mag_ff[i] <= raw_ff[4+i][ttb_pkg::RAW_W-1]
                            ? ttb_pkg::mag_type'(unsigned'(-raw_ff[4+i]))
                            : ttb_pkg::mag_type'(unsigned'(raw_ff[4+i]));
            end else begin
               neg_ff[i] <= det_neg ? (!raw_ff[1+i][ttb_pkg::RAW_W-1] && raw_ff[1+i] != '0)
                                    : raw_ff[1+i][ttb_pkg::RAW_W-1];
               mag_ff[i] <= raw_ff[1+i][ttb_pkg::RAW_W-1]
                            ? ttb_pkg::mag_type'(unsigned'(-raw_ff[1+i]))
                            : ttb_pkg::mag_type'(unsigned'(raw_ff[1+i]));
            end
         end
      end else if (cmd.norm_shift) begin
         for (int i = 0; i < 3; i++) begin
            if ((m_c >> ttb_pkg::NORM_BITS) != '0) mag_ff[i] <= mag_ff[i] >> 1;
            else                                   mag_ff[i] <= mag_ff[i] << 1;
         end
      end

      // sum of squares, then bit-serial square root
      if (cmd.sq_step) begin
         if (cmd.idx == '0) begin
            root_ff   <= '0;
            sq_bit_ff <= ttb_pkg::sum_type'(1) << (2 * (ttb_pkg::LEN_W - 1));
         end else if (cmd.idx == ttb_pkg::cnt_type'(1)) begin
            sum_ff <= ttb_pkg::sum_type'(prod_ff);
         end else begin
            sum_ff <= sum_ff + ttb_pkg::sum_type'(prod_ff);
         end
      end else if (cmd.sqrt_step) begin
         if (sum_ff >= trial) begin
            sum_ff  <= sum_ff - trial;
            root_ff <= (root_ff >> 1) + sq_bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
      end

      // restoring divide, quotient bits enter from the bottom
      if (cmd.div_init) begin
         rem_ff <= (ttb_pkg::div_type'(mag_ff[cmd.comp][ttb_pkg::NORM_BITS-1:0])
                    << ttb_pkg::OUT_FRAC) + ttb_pkg::div_type'(len >> 1);
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_ff >= div_sub) rem_ff <= rem_ff - div_sub;
         quo_ff <= {quo_ff[ttb_pkg::Q_W-2:0], rem_ff >= div_sub};
      end

      // result bank
      if (cmd.load_degen) degen_ff <= status.det_zero;
      if (cmd.zero_all) begin
         for (int i = 0; i < 3; i++) begin
            tan_ff[i]  <= '0;
            btan_ff[i] <= '0;
         end
      end
      if (cmd.zero_vec) begin
         for (int i = 0; i < 3; i++) begin
            if (cmd.vec) btan_ff[i] <= '0;
            else         tan_ff[i]  <= '0;
         end
      end
      if (cmd.div_store) begin
         if (cmd.vec) btan_ff[cmd.comp] <= store_val;
         else         tan_ff[cmd.comp]  <= store_val;
      end
   end

   assign tangent_x   = tan_ff[0];
   assign tangent_y   = tan_ff[1];
   assign tangent_z   = tan_ff[2];
   assign bitangent_x = btan_ff[0];
   assign bitangent_y = btan_ff[1];
   assign bitangent_z = btan_ff[2];
   assign degenerate  = degen_ff;

endmodule

/* design/ttb_ctrl.sv */
// ----------------------------------------------------------------------------
// ttb_ctrl: sequencer for the triangle tangent/bitangent block
// Counts corners, steps the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module ttb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  ttb_pkg::status_type status,
   output ttb_pkg::cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_MUL       = 10'b00_0000_0010,
      ST_CHECK     = 10'b00_0000_0100,
      ST_NORM      = 10'b00_0000_1000,
      ST_SQ        = 10'b00_0001_0000,
      ST_SQRT      = 10'b00_0010_0000,
      ST_DIV_INIT  = 10'b00_0100_0000,
      ST_DIV_STEP  = 10'b00_1000_0000,
      ST_DIV_STORE = 10'b01_0000_0000,
      ST_DONE      = 10'b10_0000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       corner_ff, corner_in;
   ttb_pkg::cnt_type cnt_ff, cnt_in;
   logic             vec_ff, vec_in;
   logic [1:0]       comp_ff, comp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign req_stall = (state_ff != ST_IDLE) || (corner_ff[1] && rsp_valid_ff);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      corner_in    = corner_ff;
      cnt_in       = cnt_ff;
      vec_in       = vec_ff;
      comp_in      = comp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.idx      = cnt_ff;
      cmd.vec      = vec_ff;
      cmd.comp     = comp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!corner_ff[1]) begin
                  cmd.hold_wr  = 1'b1;
                  cmd.hold_sel = corner_ff[0];
                  corner_in    = corner_ff + 2'd1;
               end else begin
                  // third corner: form edges, start the products
                  cmd.load_third = 1'b1;
                  corner_in      = '0;
                  cnt_in         = '0;
                  state_in       = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == ttb_pkg::cnt_type'(ttb_pkg::MUL_STEPS)) state_in = ST_CHECK;
            else cnt_in = cnt_ff + ttb_pkg::cnt_type'(1);
         end
         ST_CHECK: begin
            cmd.load_degen = 1'b1;
            if (status.det_zero) begin
               cmd.zero_all = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.norm_load = 1'b1;
               cmd.norm_vec  = 1'b0;
               vec_in        = 1'b0;
               state_in      = ST_NORM;
            end
         end
         ST_NORM: begin
            if (status.m_zero) begin
               cmd.zero_vec = 1'b1;
               if (!vec_ff) begin
                  cmd.norm_load = 1'b1;
                  cmd.norm_vec  = 1'b1;
                  vec_in        = 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (status.norm_ok) begin
               cnt_in   = '0;
               state_in = ST_SQ;
            end else begin
               cmd.norm_shift = 1'b1;
            end
         end
         ST_SQ: begin
            cmd.sq_step = 1'b1;
            if (cnt_ff == ttb_pkg::cnt_type'(ttb_pkg::SQ_STEPS)) begin
               cnt_in   = '0;
               state_in = ST_SQRT;
            end else begin
               cnt_in = cnt_ff + ttb_pkg::cnt_type'(1);
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == ttb_pkg::cnt_type'(ttb_pkg::SQRT_STEPS - 1)) begin
               comp_in  = '0;
               state_in = ST_DIV_INIT;
            end else begin
               cnt_in = cnt_ff + ttb_pkg::cnt_type'(1);
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = ttb_pkg::cnt_type'(ttb_pkg::OUT_FRAC);
            state_in     = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) state_in = ST_DIV_STORE;
            else cnt_in = cnt_ff - ttb_pkg::cnt_type'(1);
         end
         ST_DIV_STORE: begin
            cmd.div_store = 1'b1;
            if (comp_ff != 2'd2) begin
               comp_in  = comp_ff + 2'd1;
               state_in = ST_DIV_INIT;
            end else if (!vec_ff) begin
               cmd.norm_load = 1'b1;
               cmd.norm_vec  = 1'b1;
               vec_in        = 1'b1;
               state_in      = ST_NORM;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         corner_ff    <= '0;
         cnt_ff       <= '0;
         vec_ff       <= 1'b0;
         comp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         corner_ff    <= corner_in;
         cnt_ff       <= cnt_in;
         vec_ff       <= vec_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/triangle_tangent_bitangent.sv */
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent: tangent-space basis of a textured triangle
// Controller plus datapath; one result word per three corner words.
// ----------------------------------------------------------------------------
// Corners arrive one word each: position in signed Q12.12, texture coordinate
// in signed Q4.12. The first two corners of a triangle are taken, one per cycle
// while the block is idle, and held. The third corner starts the math and the
// input stalls until it is done: products on one shared 31x31 multiplier, a
// determinant check, then for each of tangent and bitangent one-bit
// normalizing shifts, squares, a bit-serial square root and a restoring
// divide for each of the three components. The result word holds unit vectors
// in signed Q1.14; a zero raw vector gives zeros, and a zero UV determinant
// gives all zeros with degenerate set. A result waits in the output register
// until taken; first and second corners of the next triangle are still taken
// meanwhile, its third corner waits.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ttb_pkg::pos_type req_vertex_x,
   input  ttb_pkg::pos_type req_vertex_y,
   input  ttb_pkg::pos_type req_vertex_z,
   input  ttb_pkg::uv_type  req_tex_u,
   input  ttb_pkg::uv_type  req_tex_v,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ttb_pkg::out_type rsp_tangent_x,
   output ttb_pkg::out_type rsp_tangent_y,
   output ttb_pkg::out_type rsp_tangent_z,
   output ttb_pkg::out_type rsp_bitangent_x,
   output ttb_pkg::out_type rsp_bitangent_y,
   output ttb_pkg::out_type rsp_bitangent_z,
   output logic             rsp_degenerate
);

   ttb_pkg::cmd_type    cmd;
   ttb_pkg::status_type status;

   // sequencer: corner count, step counters, handshakes
   ttb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: the result bank doubles as the output register
   ttb_datapath u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .vertex_x    (req_vertex_x),
      .vertex_y    (req_vertex_y),
      .vertex_z    (req_vertex_z),
      .tex_u       (req_tex_u),
      .tex_v       (req_tex_v),
      .status      (status),
      .tangent_x   (rsp_tangent_x),
      .tangent_y   (rsp_tangent_y),
      .tangent_z   (rsp_tangent_z),
      .bitangent_x (rsp_bitangent_x),
      .bitangent_y (rsp_bitangent_y),
      .bitangent_z (rsp_bitangent_z),
      .degenerate  (rsp_degenerate)
   );

endmodule

/* test/tb_triangle_tangent_bitangent.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_tangent_bitangent: self-checking bench for the tangent block
// Sends corner words and predicts the tangent/bitangent of each triangle in
// exact integer math. Each result word is checked against the oldest
// prediction, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_bitangent;

   typedef struct {
      ttb_pkg::out_type tan_x, tan_y, tan_z;
      ttb_pkg::out_type bit_x, bit_y, bit_z;
      logic             degen;
   } basis_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ttb_pkg::pos_type req_vertex_x = '0, req_vertex_y = '0, req_vertex_z = '0;
   ttb_pkg::uv_type  req_tex_u = '0, req_tex_v = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ttb_pkg::out_type rsp_tangent_x, rsp_tangent_y, rsp_tangent_z;
   ttb_pkg::out_type rsp_bitangent_x, rsp_bitangent_y, rsp_bitangent_z;
   logic             rsp_degenerate;

   basis_type basis_queue[$];
   int        error_count = 0;
   int        cycle_count = 0;
   bit        calm = 1'b0;      // no idling on either side while set

   // predictor state: corners held so far and the count of them
   int          held_corners = 0;
   longint      held_pos[6];
   longint      held_uv[4];

   triangle_tangent_bitangent uut (.*);

   always #5 clock = ~clock;

   // Generous limit on the run length, stalls included, many times over.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("tb_triangle_tangent_bitangent failed");
         $finish;
      end
   end

   // Integer square root, floor.
   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Scale a raw vector so its largest magnitude lies in [2^29, 2^30),
   // then divide by the rounded-down length with rounding to nearest.
   function automatic void unit_of(input longint r[3], output ttb_pkg::out_type o[3]);
      longint unsigned mag[3], m, sumsq, len, q;
      bit neg[3];
      m = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = r[i] < 0;
         mag[i] = neg[i] ? -r[i] : r[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         for (int i = 0; i < 3; i++) o[i] = '0;
         return;
      end
      while (m >= (64'd1 << 30)) begin
         m >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (m < (64'd1 << 29)) begin
         m <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      sumsq = 0;
      for (int i = 0; i < 3; i++) sumsq += mag[i] * mag[i];
      len = root_floor(sumsq);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << ttb_pkg::OUT_FRAC) + (len >> 1)) / len;
         o[i] = neg[i] ? ttb_pkg::out_type'(-q) : ttb_pkg::out_type'(q);
      end
   endfunction

   // Advance the predictor by one corner; queue a basis on the third.
   function automatic void predict_basis(ttb_pkg::pos_type x, ttb_pkg::pos_type y,
                                         ttb_pkg::pos_type z,
                                         ttb_pkg::uv_type u, ttb_pkg::uv_type v);
      longint p[3], e0[3], e1[3], rt[3], rb[3];
      longint du0, dv0, du1, dv1, det;
      ttb_pkg::out_type t[3], b[3];
      basis_type res;
      p[0] = x; p[1] = y; p[2] = z;
      if (held_corners < 2) begin
         for (int i = 0; i < 3; i++) held_pos[held_corners*3 + i] = p[i];
         held_uv[held_corners*2] = u;
         held_uv[held_corners*2 + 1] = v;
         held_corners++;
         return;
      end
      held_corners = 0;
      for (int i = 0; i < 3; i++) begin
         e0[i] = held_pos[3+i] - held_pos[i];
         e1[i] = p[i] - held_pos[i];
      end
      du0 = held_uv[2] - held_uv[0];
      dv0 = held_uv[3] - held_uv[1];
      du1 = longint'(u) - held_uv[0];
      dv1 = longint'(v) - held_uv[1];
      det = du0 * dv1 - dv0 * du1;
      res = '{default: '0};
      if (det == 0) begin
         res.degen = 1'b1;
      end else begin
         for (int i = 0; i < 3; i++) begin
            rt[i] = e0[i] * dv1 - e1[i] * dv0;
            rb[i] = e1[i] * du0 - e0[i] * du1;
            if (det < 0) begin
               rt[i] = -rt[i];
               rb[i] = -rb[i];
            end
         end
         unit_of(rt, t);
         unit_of(rb, b);
         res.tan_x = t[0]; res.tan_y = t[1]; res.tan_z = t[2];
         res.bit_x = b[0]; res.bit_y = b[1]; res.bit_z = b[2];
      end
      basis_queue.insert(basis_queue.size(), res);
   endfunction

   // Send one corner word; idle first at random, hold until taken.
   task automatic send_corner(ttb_pkg::pos_type x, ttb_pkg::pos_type y,
                              ttb_pkg::pos_type z,
                              ttb_pkg::uv_type u, ttb_pkg::uv_type v);
      while (!calm && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vertex_x <= x; req_vertex_y <= y; req_vertex_z <= z;
      req_tex_u <= u; req_tex_v <= v;
      predict_basis(x, y, z, u, v);
      do @(posedge clock); while (req_stall);
   endtask

   // Receiver: stall at random, check each word taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (basis_queue.size() == 0) begin
               $error("result word with no prediction waiting");
               error_count++;
            end else begin
               basis_type e;
               e = basis_queue.pop_front();
               if (rsp_tangent_x !== e.tan_x) begin
                  $error("tangent_x exp %0d got %0d", e.tan_x, rsp_tangent_x); error_count++;
               end
               if (rsp_tangent_y !== e.tan_y) begin
                  $error("tangent_y exp %0d got %0d", e.tan_y, rsp_tangent_y); error_count++;
               end
               if (rsp_tangent_z !== e.tan_z) begin
                  $error("tangent_z exp %0d got %0d", e.tan_z, rsp_tangent_z); error_count++;
               end
               if (rsp_bitangent_x !== e.bit_x) begin
                  $error("bitangent_x exp %0d got %0d", e.bit_x, rsp_bitangent_x);
                  error_count++;
               end
               if (rsp_bitangent_y !== e.bit_y) begin
                  $error("bitangent_y exp %0d got %0d", e.bit_y, rsp_bitangent_y);
                  error_count++;
               end
               if (rsp_bitangent_z !== e.bit_z) begin
                  $error("bitangent_z exp %0d got %0d", e.bit_z, rsp_bitangent_z);
                  error_count++;
               end
               if (rsp_degenerate !== e.degen) begin
                  $error("degenerate exp %0d got %0d", e.degen, rsp_degenerate);
                  error_count++;
               end
            end
         end
      end
      rsp_stall <= !calm && ($urandom_range(99) < 29);
   end

   // Directed triangles: extremes, zero determinant, zero raw vectors, signs.
   task automatic test_directed();
      // plain right triangle
      send_corner(0, 0, 0, 0, 0);
      send_corner(24'sd4096, 0, 0, 16'sd4096, 0);
      send_corner(0, 24'sd4096, 0, 0, 16'sd4096);
      // mirrored UVs: negative determinant
      send_corner(0, 0, 0, 0, 0);
      send_corner(24'sd4096, 0, 0, -16'sd4096, 0);
      send_corner(0, 24'sd4096, 0, 0, 16'sd4096);
      // zero determinant: all UVs equal
      send_corner(24'sd100, 24'sd200, 24'sd300, 16'sd7, 16'sd7);
      send_corner(24'sd400, -24'sd5, 24'sd9, 16'sd7, 16'sd7);
      send_corner(-24'sd77, 24'sd3, 24'sd1, 16'sd7, 16'sd7);
      // all positions equal: zero raw vectors with nonzero determinant
      send_corner(24'sd55, 24'sd55, 24'sd55, 0, 0);
      send_corner(24'sd55, 24'sd55, 24'sd55, 16'sd1, 0);
      send_corner(24'sd55, 24'sd55, 24'sd55, 0, 16'sd1);
      // position and UV extremes
      send_corner(24'h800000, 24'h7FFFFF, 24'h800000, 16'h8000, 16'h7FFF);
      send_corner(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h7FFF, 16'h8000);
      send_corner(24'h800000, 24'h800000, 24'h7FFFFF, 16'h8000, 16'h8000);
      send_corner(24'hFFFFFF, 0, 24'h000001, 16'hFFFF, 16'h0001);
      send_corner(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 16'h7FFF);
      send_corner(24'h800000, 24'h800000, 24'h800000, 16'h8000, 16'h0000);
   endtask

   // Random triangles: mostly full-range, some small, some with shared UVs.
   task automatic test_random(int corners);
      ttb_pkg::pos_type x, y, z;
      ttb_pkg::uv_type  u, v;
      for (int n = 0; n < corners; n++) begin
         calm = (n >= 300 && n < 420);
         case ($urandom_range(3))
            0: begin
               x = ttb_pkg::pos_type'(int'($urandom_range(32)) - 16);
               y = ttb_pkg::pos_type'(int'($urandom_range(32)) - 16);
               z = ttb_pkg::pos_type'(int'($urandom_range(32)) - 16);
               u = ttb_pkg::uv_type'(int'($urandom_range(8)) - 4);
               v = ttb_pkg::uv_type'(int'($urandom_range(8)) - 4);
            end
            1: begin
               x = ttb_pkg::pos_type'($urandom);
               y = ttb_pkg::pos_type'($urandom);
               z = ttb_pkg::pos_type'($urandom);
               u = 16'sd4096;
               v = ttb_pkg::uv_type'(int'($urandom_range(3)) - 1);
            end
            default: begin
               x = ttb_pkg::pos_type'($urandom);
               y = ttb_pkg::pos_type'($urandom);
               z = ttb_pkg::pos_type'($urandom);
               u = ttb_pkg::uv_type'($urandom);
               v = ttb_pkg::uv_type'($urandom);
            end
         endcase
         send_corner(x, y, z, u, v);
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1032);
      req_valid <= 1'b0;
      while (basis_queue.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_triangle_tangent_bitangent passed");
      end else begin
         $display("tb_triangle_tangent_bitangent failed");
      end
      $finish;
   end

endmodule

/* files.f */
design/ttb_pkg.sv
design/ttb_datapath.sv
design/ttb_ctrl.sv
design/triangle_tangent_bitangent.sv
test/tb_triangle_tangent_bitangent.sv
